>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the body resonator.
// Each macro wraps a clocked concurrent assertion that is disabled while the active-low reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/pbbr_pkg.sv
// Package for the parallel bandpass body resonator.
// Holds the fixed widths, register reset values, codes and the state saturation helper.
`default_nettype none
package pbbr_pkg;
    localparam int NUM_MODES_DEF      = 8;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 22;

    localparam int GUARD_BITS     = 8;
    localparam int STATE_W        = 48;
    localparam int COEF_W         = 26;
    localparam int COEFS_PER_MODE = 6;
    localparam int POLE_W         = 24;
    localparam int MIX_W          = 17;
    localparam int CFG_W          = 24;
    localparam int WIDE_W         = 80;

    localparam logic [MIX_W-1:0]  MIX_RESET  = 17'd32768;
    localparam logic [MIX_W-1:0]  MIX_FULL   = 17'd65536;
    localparam logic [POLE_W-1:0] POLE_RESET = 24'd16700526;

    // Configuration register indexes.
    localparam logic CFG_MIX     = 1'b0;
    localparam logic CFG_HP_POLE = 1'b1;

    // Input item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    // Coefficient selects within one section.
    localparam logic [2:0] SEL_B0   = 3'd0;
    localparam logic [2:0] SEL_B1   = 3'd1;
    localparam logic [2:0] SEL_B2   = 3'd2;
    localparam logic [2:0] SEL_A1   = 3'd3;
    localparam logic [2:0] SEL_A2   = 3'd4;
    localparam logic [2:0] SEL_GAIN = 3'd5;

    typedef logic signed [STATE_W-1:0] t_state;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    function automatic t_state sat_state(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (STATE_W - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/parallel_bandpass_body_resonator_core.sv
// Top level of the parallel bandpass body resonator: dry highpass, bandpass bank, blend.
// Depends on pbbr_pkg and assert_macros.svh.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     kind, sample_in, mode_index,
//                                                   coef_select, coef_value
//  output    out        o_out_valid / i_out_stall   sample_out
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// A coefficient write transaction is taken in S_IDLE and does not leave it. An audio sample
// passes S_DMUL and S_DRND, then S_CRD (coefficient memory read), S_CMUL, S_CRND and S_CAPL
// for each of the six coefficients of every section, then S_WET, S_BLEND and S_OUT; the next
// transaction is taken once the core is back in S_IDLE. The 48 by 26 product is shared.
// Reset is synchronous; it clears the filter state and the coefficient valid bits.
// The result waits in an output register; input is taken again while it waits.
`default_nettype none
`include "assert_macros.svh"
module parallel_bandpass_body_resonator_core #(
    parameter int NUM_MODES      = pbbr_pkg::NUM_MODES_DEF,
    parameter int SAMPLE_BITS    = pbbr_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = pbbr_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_kind,
    input  wire signed [SAMPLE_BITS-1:0]      i_sample_in,
    input  wire [2:0]                         i_mode_index,
    input  wire [2:0]                         i_coef_select,
    input  wire signed [pbbr_pkg::COEF_W-1:0] i_coef_value,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_idx,
    input  wire [pbbr_pkg::CFG_W-1:0]         i_cfg_data
);
    import pbbr_pkg::*;

    localparam int NUM_COEF = NUM_MODES * COEFS_PER_MODE;
    localparam int CA_W     = $clog2(NUM_COEF);
    localparam int MODE_W   = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int ACC_W    = STATE_W + $clog2(NUM_MODES) + 1;
    localparam int DIFF_W   = SAMPLE_BITS + 2;
    localparam int DPROD_W  = DIFF_W + POLE_W + 1;
    localparam int BPROD_W  = SAMPLE_BITS + MIX_W + 1;
    localparam int FULL_W   = 75;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DMUL  = 4'd1;
    localparam logic [3:0] S_DRND  = 4'd2;
    localparam logic [3:0] S_CRD   = 4'd3;
    localparam logic [3:0] S_CMUL  = 4'd4;
    localparam logic [3:0] S_CRND  = 4'd5;
    localparam logic [3:0] S_CAPL  = 4'd6;
    localparam logic [3:0] S_WET   = 4'd7;
    localparam logic [3:0] S_BLEND = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (SAMPLE_BITS - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    logic [3:0]                    r_state;
    logic [MIX_W-1:0]              r_mix;
    logic [POLE_W-1:0]             r_pole;
    logic [MODE_W-1:0]             r_mode;
    logic [2:0]                    r_sel;
    logic signed [SAMPLE_BITS-1:0] r_prev_in;
    logic signed [SAMPLE_BITS-1:0] r_prev_dry;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [DIFF_W-1:0]      r_diff;
    logic signed [DPROD_W-1:0]     r_dprod;
    logic signed [SAMPLE_BITS-1:0] r_dry;
    logic signed [49:0]            r_phi;
    logic signed [50:0]            r_plo;
    t_state                        r_prod;
    t_state                        r_y;
    t_state                        r_t1;
    t_state                        r_t2;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [SAMPLE_BITS-1:0] r_wet_s;
    logic signed [BPROD_W-1:0]     r_b1;
    logic signed [BPROD_W-1:0]     r_b2;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    // Coefficient store and section state memories with per-entry valid bits.
    logic signed [COEF_W-1:0] r_coef_mem [NUM_COEF];
    logic [NUM_COEF-1:0]      r_coef_vld;
    logic signed [COEF_W-1:0] r_coef_q;
    logic                     r_coef_vq;
    t_state                   r_s1_mem [NUM_MODES];
    t_state                   r_s2_mem [NUM_MODES];
    logic [NUM_MODES-1:0]     r_s1_vld;
    logic [NUM_MODES-1:0]     r_s2_vld;
    t_state                   r_s1_q;
    t_state                   r_s2_q;
    logic                     r_s1_vq;
    logic                     r_s2_vq;

    logic                     in_acc;
    logic                     out_acc;
    logic                     wr_ok;
    logic [CA_W-1:0]          wr_addr;
    logic [CA_W-1:0]          rd_addr;
    logic                     s1_we;
    logic                     s2_we;
    t_state                   s1_new;
    t_state                   s2_new;
    logic signed [COEF_W-1:0] coef;
    t_state                   s1_old;
    t_state                   s2_old;
    t_state                   op_a;
    logic signed [FULL_W-1:0] full;
    logic signed [FULL_W-1:0] full_rnd;
    t_wide                    dry_rnd;
    t_state                   wet48;
    t_wide                    wet_rnd;
    logic [MIX_W-1:0]         m_eff;
    logic [MIX_W-1:0]         m_inv;
    t_wide                    blend_rnd;
    logic signed [SAMPLE_BITS-1:0] dry_next;

    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_acc      = r_out_valid && !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    assign wr_ok   = in_acc && (i_kind == KIND_WRITE)
                     && ({3'b000, i_mode_index} < 6'(NUM_MODES))
                     && (i_coef_select <= SEL_GAIN);
    assign wr_addr = CA_W'(({5'd0, i_mode_index} * 8'd6) + {5'd0, i_coef_select});
    assign rd_addr = CA_W'((8'(r_mode) * 8'd6) + {5'd0, r_sel});

    assign coef   = r_coef_vq ? r_coef_q : '0;
    assign s1_old = r_s1_vq ? r_s1_q : '0;
    assign s2_old = r_s2_vq ? r_s2_q : '0;
    assign op_a   = (r_sel < SEL_A1) ? (STATE_W'(r_x) <<< GUARD_BITS) : r_y;

    assign full     = (FULL_W'(r_phi) <<< 24) + FULL_W'(r_plo);
    assign full_rnd = (full + (FULL_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;

    assign s1_we  = (r_state == S_CAPL) && (r_sel == SEL_A1);
    assign s2_we  = (r_state == S_CAPL) && (r_sel == SEL_A2);
    assign s1_new = sat_state(t_wide'(r_t1) - t_wide'(r_prod) + t_wide'(s2_old));
    assign s2_new = sat_state(t_wide'(r_t2) - t_wide'(r_prod));

    assign dry_rnd  = (t_wide'(r_dprod) + (t_wide'(1) <<< (POLE_W - 1))) >>> POLE_W;
    assign dry_next = sat_smp(dry_rnd);
    assign wet48    = sat_state(t_wide'(r_acc));
    assign wet_rnd  = (t_wide'(wet48) + (t_wide'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    assign m_eff    = (r_mix > MIX_FULL) ? MIX_FULL : r_mix;
    assign m_inv    = MIX_FULL - m_eff;
    assign blend_rnd = (t_wide'(r_b1) + t_wide'(r_b2) + (t_wide'(1) <<< 15)) >>> 16;

    // Memories: synchronous read every cycle at the current section and select.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_coef_mem[wr_addr] <= i_coef_value;
        end
        if (s1_we) begin
            r_s1_mem[r_mode] <= s1_new;
        end
        if (s2_we) begin
            r_s2_mem[r_mode] <= s2_new;
        end
        r_coef_q <= r_coef_mem[rd_addr];
        r_s1_q   <= r_s1_mem[r_mode];
        r_s2_q   <= r_s2_mem[r_mode];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_s1_vld   <= '0;
            r_s2_vld   <= '0;
            r_coef_vq  <= 1'b0;
            r_s1_vq    <= 1'b0;
            r_s2_vq    <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_coef_vld[wr_addr] <= 1'b1;
            end
            if (s1_we) begin
                r_s1_vld[r_mode] <= 1'b1;
            end
            if (s2_we) begin
                r_s2_vld[r_mode] <= 1'b1;
            end
            r_coef_vq <= r_coef_vld[rd_addr];
            r_s1_vq   <= r_s1_vld[r_mode];
            r_s2_vq   <= r_s2_vld[r_mode];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_SAMPLE)) begin
            r_x    <= i_sample_in;
            r_diff <= DIFF_W'(r_prev_dry) + DIFF_W'(i_sample_in) - DIFF_W'(r_prev_in);
        end
        r_dprod <= $signed({1'b0, r_pole}) * r_diff;
        r_phi   <= $signed(op_a[STATE_W-1:24]) * coef;
        r_plo   <= $signed({1'b0, op_a[23:0]}) * coef;
        r_prod  <= sat_state(t_wide'(full_rnd));
        if (r_state == S_DRND) begin
            r_dry <= dry_next;
        end
        if (r_state == S_CAPL) begin
            case (r_sel)
                SEL_B0:  r_y  <= sat_state(t_wide'(r_prod) + t_wide'(s1_old));
                SEL_B1:  r_t1 <= r_prod;
                SEL_B2:  r_t2 <= r_prod;
                default: ;
            endcase
        end
        r_wet_s <= sat_smp(wet_rnd);
        r_b1    <= $signed({1'b0, m_inv}) * r_dry;
        r_b2    <= $signed({1'b0, m_eff}) * r_wet_s;
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mix       <= MIX_RESET;
            r_pole      <= POLE_RESET;
            r_mode      <= '0;
            r_sel       <= SEL_B0;
            r_prev_in   <= '0;
            r_prev_dry  <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIX:     r_mix  <= i_cfg_data[MIX_W-1:0];
                    CFG_HP_POLE: r_pole <= i_cfg_data[POLE_W-1:0];
                    default:     ;
                endcase
            end
            // In the output state a taken result is replaced by the new one below.
            if (out_acc && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_kind == KIND_SAMPLE)) begin
                        r_prev_in <= i_sample_in;
                        r_mode    <= '0;
                        r_sel     <= SEL_B0;
                        r_acc     <= '0;
                        r_state   <= S_DMUL;
                    end
                end
                S_DMUL: r_state <= S_DRND;
                S_DRND: begin
                    r_prev_dry <= dry_next;
                    r_state    <= S_CRD;
                end
                S_CRD:  r_state <= S_CMUL;
                S_CMUL: r_state <= S_CRND;
                S_CRND: r_state <= S_CAPL;
                S_CAPL: begin
                    if (r_sel == SEL_GAIN) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                        r_sel <= SEL_B0;
                        if (r_mode == MODE_W'(NUM_MODES - 1)) begin
                            r_state <= S_WET;
                        end else begin
                            r_mode  <= r_mode + 1'b1;
                            r_state <= S_CRD;
                        end
                    end else begin
                        r_sel   <= r_sel + 3'd1;
                        r_state <= S_CRD;
                    end
                end
                S_WET:   r_state <= S_BLEND;
                S_BLEND: r_state <= S_OUT;
                S_OUT: begin
                    // Hold here until the output register is free.
                    if (!r_out_valid || out_acc) begin
                        r_out       <= sat_smp(blend_rnd);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_OUT)
    `ASSERT_NEVER(a_sel_range, i_clk, i_rst_n, r_sel > SEL_GAIN)
    `ASSERT_CLK(a_mode_range, i_clk, i_rst_n, (r_state != S_IDLE) |-> (32'(r_mode) < NUM_MODES))
endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench for parallel_bandpass_body_resonator_core: drives audio and coefficient-write
// transactions with random idling and checks every output sample against a bit-exact model.
// Depends on pbbr_pkg and the RTL of the core.
`timescale 1ns / 100ps
`default_nettype none

import pbbr_pkg::*;

class resonator_scoreboard;
    logic [MIX_W-1:0]         mix;
    logic [POLE_W-1:0]        pole;
    logic signed [COEF_W-1:0] coefs [NUM_MODES_DEF*COEFS_PER_MODE];
    t_wide                    state_one [NUM_MODES_DEF];
    t_wide                    state_two [NUM_MODES_DEF];
    t_wide                    last_input;
    t_wide                    last_dry;
    logic signed [SAMPLE_BITS_DEF-1:0] pending_samples [$];
    int errors;
    int samples;
    int writes;

    function new();
        mix = MIX_RESET;
        pole = POLE_RESET;
        foreach (coefs[i]) coefs[i] = '0;
        foreach (state_one[i]) begin
            state_one[i] = '0;
            state_two[i] = '0;
        end
        last_input = '0;
        last_dry = '0;
        errors = 0;
        samples = 0;
        writes = 0;
    endfunction

    static function t_wide clamp(t_wide v, int bits);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Rounded product with a Q3.22 coefficient, held to the 48-bit state range.
    static function t_wide coef_product(t_wide a, logic signed [COEF_W-1:0] c);
        t_wide p;
        p = a * t_wide'(c) + (t_wide'(1) <<< (COEF_FRAC_BITS_DEF - 1));
        return clamp(p >>> COEF_FRAC_BITS_DEF, STATE_W);
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] data);
        if (idx == CFG_MIX) mix = data[MIX_W-1:0];
        else pole = data;
    endfunction

    function void note_input(logic kind, logic signed [SAMPLE_BITS_DEF-1:0] x,
                             logic [2:0] mode, logic [2:0] sel,
                             logic signed [COEF_W-1:0] value);
        t_wide xs, m, diff, dry, y, wet, wet_s, blend, c_x;
        int base;
        if (kind == KIND_WRITE) begin
            writes++;
            if (sel <= SEL_GAIN) coefs[mode*COEFS_PER_MODE + sel] = value;
            return;
        end
        samples++;
        c_x = t_wide'(x);
        m = (mix > MIX_FULL) ? t_wide'(MIX_FULL) : t_wide'(mix);
        diff = last_dry + c_x - last_input;
        dry = clamp((t_wide'(pole) * diff + (t_wide'(1) <<< (POLE_W - 1))) >>> POLE_W,
                    SAMPLE_BITS_DEF);
        last_input = c_x;
        last_dry = dry;
        xs = c_x <<< GUARD_BITS;
        wet = '0;
        for (int i = 0; i < NUM_MODES_DEF; i++) begin
            base = i * COEFS_PER_MODE;
            y = clamp(coef_product(xs, coefs[base + SEL_B0]) + state_one[i], STATE_W);
            state_one[i] = clamp(coef_product(xs, coefs[base + SEL_B1])
                                 - coef_product(y, coefs[base + SEL_A1])
                                 + state_two[i], STATE_W);
            state_two[i] = clamp(coef_product(xs, coefs[base + SEL_B2])
                                 - coef_product(y, coefs[base + SEL_A2]), STATE_W);
            wet = wet + coef_product(y, coefs[base + SEL_GAIN]);
        end
        wet = clamp(wet, STATE_W);
        wet_s = clamp((wet + (t_wide'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS,
                      SAMPLE_BITS_DEF);
        blend = (t_wide'(MIX_FULL) - m) * dry + m * wet_s;
        pending_samples.push_back(
            SAMPLE_BITS_DEF'(clamp((blend + 32768) >>> 16, SAMPLE_BITS_DEF)));
    endfunction

    function void check_result(logic signed [SAMPLE_BITS_DEF-1:0] actual);
        logic signed [SAMPLE_BITS_DEF-1:0] want;
        if (pending_samples.size() == 0) begin
            $display("%0t: unexpected output sample, expected none, actual %0d",
                     $realtime, actual);
            errors++;
            return;
        end
        want = pending_samples.pop_front();
        if (actual !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $realtime, want, actual);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 250;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_kind = KIND_SAMPLE;
    logic signed [SAMPLE_BITS_DEF-1:0] i_sample_in = '0;
    logic [2:0] i_mode_index = '0;
    logic [2:0] i_coef_select = '0;
    logic signed [COEF_W-1:0] i_coef_value = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS_DEF-1:0] o_sample_out;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = CFG_MIX;
    logic [CFG_W-1:0] i_cfg_data = '0;

    resonator_scoreboard sb = new();
    bit steady = 1'b0;
    int quiet_cycles = 0;

    parallel_bandpass_body_resonator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_sample_in(i_sample_in), .i_mode_index(i_mode_index),
        .i_coef_select(i_coef_select), .i_coef_value(i_coef_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_sample_out(o_sample_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_sample_out);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("parallel_bandpass_body_resonator_core verification failed");
            $finish;
        end
    end

    task automatic send_item(logic kind, logic signed [SAMPLE_BITS_DEF-1:0] x,
                             logic [2:0] mode, logic [2:0] sel,
                             logic signed [COEF_W-1:0] value);
        while (!steady && $urandom_range(99) < 31) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_sample_in <= x;
        i_mode_index <= mode;
        i_coef_select <= sel;
        i_coef_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(kind, x, mode, sel, value);
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS_DEF-1:0] x);
        send_item(KIND_SAMPLE, x, 3'($urandom), 3'($urandom), COEF_W'($urandom));
    endtask

    task automatic send_write(logic [2:0] mode, logic [2:0] sel,
                              logic signed [COEF_W-1:0] value);
        send_item(KIND_WRITE, SAMPLE_BITS_DEF'($urandom), mode, sel, value);
    endtask

    // Waits until every expected sample has been taken from the core.
    task automatic drain();
        while (sb.pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only once the core has drained.
    task automatic write_register(logic idx, logic [CFG_W-1:0] data);
        @(negedge i_clk) i_in_valid <= 1'b0;
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        sb.set_register(idx, data);
    endtask

    function automatic logic signed [COEF_W-1:0] random_coef();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return COEF_W'($signed($urandom_range(2097152)) - 1048576);
        if (pick < 90) return COEF_W'($signed($urandom_range(8388608)) - 4194304);
        return COEF_W'($urandom);
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 20) begin
                send_write(3'($urandom), 3'($urandom_range(7)), random_coef());
            end else if ($urandom_range(9) == 0) begin
                send_sample(SAMPLE_BITS_DEF'($urandom));
            end else begin
                send_sample(SAMPLE_BITS_DEF'($signed($urandom_range(2000000)) - 1000000));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: silent bank, extremes of the sample, then a loaded bank.
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample('0);
        for (int s = 0; s < 8; s++) send_write(3'(s), 3'(s), 26'sh1FFFFFF);
        send_write(3'd7, SEL_B0, 26'sh2000000);
        send_write(3'd0, SEL_B0, 26'sd1048576);
        send_write(3'd0, SEL_B2, -26'sd1048576);
        send_write(3'd0, SEL_A1, -26'sd7000000);
        send_write(3'd0, SEL_A2, 26'sd3900000);
        send_write(3'd0, SEL_GAIN, 26'sd4194304);
        send_write(3'd3, 3'd6, 26'sh1234567);
        send_write(3'd3, 3'd7, 26'sh2ABCDEF);
        send_sample(24'sh7FFFFF);
        send_sample(24'sh800000);
        send_sample(24'sd1);
        send_sample(-24'sd1);

        write_register(CFG_MIX, 24'd0);
        write_register(CFG_HP_POLE, 24'hFFFFFF);
        random_phase(260);
        write_register(CFG_MIX, 24'd65536);
        write_register(CFG_HP_POLE, 24'd0);
        steady = 1'b1;
        random_phase(260);
        steady = 1'b0;
        write_register(CFG_MIX, 24'hFFFFFF);
        write_register(CFG_HP_POLE, 24'd16700526);
        random_phase(260);
        write_register(CFG_MIX, CFG_W'($urandom_range(65536)));
        write_register(CFG_HP_POLE, CFG_W'($urandom));
        random_phase(260);
        write_register(CFG_MIX, 24'd32768);
        random_phase(260);

        @(negedge i_clk) i_in_valid <= 1'b0;
        drain();
        $display("Covered %0d audio and %0d coefficient-write transactions over", sb.samples,
                 sb.writes);
        $display("mix at zero, full and above full, and pole at zero, maximum and random.");
        if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
            $display("parallel_bandpass_body_resonator_core verification clean");
        end else begin
            $display("parallel_bandpass_body_resonator_core verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> parallel_bandpass_body_resonator_core.f
+incdir+rtl
rtl/pbbr_pkg.sv
rtl/parallel_bandpass_body_resonator_core.sv
sim/testbench.sv
